// File: hdl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

   // Width of the frame slot field reported with every result.
   localparam int FRAME_SLOT_W = 3;

   // Configuration register layout.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int ACTIVE_W     = 4;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   // Word index of each configuration register (byte address bit 2).
   localparam logic CSR_IDX_ACTIVE_FRAMES = 1'b0;

   // Control part of one result, passed from the lookup to the top level.
   typedef struct packed {
      logic                    fault;
      logic [FRAME_SLOT_W-1:0] frame_slot;
      logic                    evicted_valid;
   } cpr_result_type;

endpackage

`default_nettype wire

// File: hdl/cpr_if.sv
// ----------------------------------------------------------------------------
// cpr_if
// Request and response channel interfaces for the clock page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

// Page reference channel.
interface cpr_req_if #(
   parameter int PAGE_BITS = 20
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

// Result channel.
interface cpr_rsp_if #(
   parameter int PAGE_BITS = 20
);
   logic                 valid;
   logic                 ready;
   logic                 fault;
   logic [2:0]           frame_slot;
   logic                 evicted_valid;
   logic [PAGE_BITS-1:0] evicted_page;

   modport source (output valid, output fault, output frame_slot,
                   output evicted_valid, output evicted_page, input ready);
   modport sink   (input valid, input fault, input frame_slot,
                   input evicted_valid, input evicted_page, output ready);
endinterface

`default_nettype wire

// File: hdl/cpr_csr.sv
// ----------------------------------------------------------------------------
// cpr_csr
// APB-style register port holding the active frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_csr
   import cpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [ACTIVE_W-1:0]   active_frames
);

   logic [ACTIVE_W-1:0] active_ff;
   logic [ACTIVE_W-1:0] active_in;
   logic                wr_active;

   // The port never inserts wait states.
   assign csr_pready = 1'b1;

   // A write lands in the access phase; the register is decoded by word index.
   assign wr_active = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr[2] == CSR_IDX_ACTIVE_FRAMES);
   assign active_in = wr_active ? csr_pwdata[ACTIVE_W-1:0] : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   // Read data for the addressed register; unmapped words read as zero.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_ACTIVE_FRAMES) begin
         csr_prdata = CSR_DATA_W'(active_ff);
      end
   end

   assign active_frames = active_ff;

endmodule

`default_nettype wire

// File: hdl/cpr_lookup.sv
// ----------------------------------------------------------------------------
// cpr_lookup
// Frame ring with parallel page compare, fill and clock-style victim choice.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_lookup
   import cpr_pkg::*;
#(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [PAGE_BITS-1:0] page,
   input  wire logic [ACTIVE_W-1:0]  active_frames,
   output cpr_result_type            result,
   output logic      [PAGE_BITS-1:0] evicted_page
);

   localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W  = ((CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W) + 1;

   // Frame contents; a slot is only read once the fill count covers it.
   logic [PAGE_BITS-1:0] frames_ff [MAX_FRAMES];

   logic [CNT_W-1:0]  filled_ff;
   logic [CNT_W-1:0]  filled_in;
   logic [SLOT_W-1:0] marked_ff;
   logic [SLOT_W-1:0] marked_in;
   logic              ref_any_ff;

   logic              hit;
   logic [SLOT_W-1:0] hit_slot;
   logic [CMP_W-1:0]  act_ext;
   logic [CMP_W-1:0]  limit;
   logic              has_free;
   logic [CNT_W:0]    next_marked;
   logic [SLOT_W-1:0] victim;
   logic [SLOT_W-1:0] slot;
   logic              write_frame;

   // Parallel compare over filled frames; the lowest matching slot wins.
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < filled_ff) && (frames_ff[i] == page)) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   // Active frame count clamped to the range 1 to MAX_FRAMES.
   always_comb begin
      act_ext = CMP_W'(active_frames);
      priority if (act_ext == '0) begin
         limit = CMP_W'(1);
      end else if (act_ext > CMP_W'(MAX_FRAMES)) begin
         limit = CMP_W'(MAX_FRAMES);
      end else begin
         limit = act_ext;
      end
   end

   assign has_free = CMP_W'(filled_ff) < limit;

   // Victim is the frame after the referenced one, wrapping over filled frames.
   assign next_marked = (CNT_W + 1)'(marked_ff) + (CNT_W + 1)'(1);
   assign victim = (ref_any_ff && (next_marked < (CNT_W + 1)'(filled_ff))) ?
                   next_marked[SLOT_W-1:0] : '0;

   // Slot selection and result for the current reference.
   always_comb begin
      result       = '0;
      evicted_page = '0;
      write_frame  = 1'b0;
      slot         = '0;
      filled_in    = filled_ff;
      priority if (hit) begin
         slot = hit_slot;
      end else if (has_free) begin
         slot         = filled_ff[SLOT_W-1:0];
         write_frame  = 1'b1;
         filled_in    = filled_ff + CNT_W'(1);
         result.fault = 1'b1;
      end else begin
         slot                 = victim;
         write_frame          = 1'b1;
         result.fault         = 1'b1;
         result.evicted_valid = 1'b1;
         evicted_page         = frames_ff[victim];
      end
      result.frame_slot = FRAME_SLOT_W'(slot);
   end

   assign marked_in = slot;

   // Control state: fill count and the single referenced frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff  <= '0;
         marked_ff  <= '0;
         ref_any_ff <= 1'b0;
      end else if (step) begin
         filled_ff  <= filled_in;
         marked_ff  <= marked_in;
         ref_any_ff <= 1'b1;
      end
   end

   // Frame contents are written on every fault.
   always_ff @(posedge clock) begin
      if (step && write_frame) begin
         frames_ff[slot] <= page;
      end
   end

endmodule

`default_nettype wire

// File: hdl/clock_page_replacement.sv
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock-style page replacement over a ring of up to MAX_FRAMES frames.
// ----------------------------------------------------------------------------
// The block takes one page reference per clock cycle while the result channel
// is not stalled, and returns one result for each, in order. A reference is
// registered, compared against all filled frames at once, and its result
// registered at the same edge that updates the frame ring, so the next
// reference already sees the new state. The parallel compare over MAX_FRAMES
// frames of PAGE_BITS each sets the cycle time. The user must write the active
// frame count through the configuration port only while no references are in
// flight; the block itself does not enforce this.
`default_nettype none

module clock_page_replacement
   import cpr_pkg::*;
#(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cpr_req_if.sink                    req_ch,
   cpr_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [ACTIVE_W-1:0]  active_frames;

   logic                 in_valid_ff;
   logic [PAGE_BITS-1:0] in_page_ff;
   logic                 out_valid_ff;
   cpr_result_type       out_res_ff;
   logic [PAGE_BITS-1:0] out_evicted_ff;

   logic                 advance;
   logic                 accept;
   cpr_result_type       step_res;
   logic [PAGE_BITS-1:0] step_evicted;

   // Configuration registers.
   cpr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .active_frames (active_frames)
   );

   // The held request moves on when the result register is free or drains.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   // Frame ring and policy.
   cpr_lookup #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_lookup (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .page          (in_page_ff),
      .active_frames (active_frames),
      .result        (step_res),
      .evicted_page  (step_evicted)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_page_ff <= req_ch.page;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff     <= step_res;
         out_evicted_ff <= step_evicted;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.fault         = out_res_ff.fault;
   assign rsp_ch.frame_slot    = out_res_ff.frame_slot;
   assign rsp_ch.evicted_valid = out_res_ff.evicted_valid;
   assign rsp_ch.evicted_page  = out_evicted_ff;

endmodule

`default_nettype wire

// File: hdl/cpr_checker.sv
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks for the clock page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_checker #(
   parameter int PAGE_BITS = 20
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 fault,
   input wire logic [2:0]           frame_slot,
   input wire logic                 evicted_valid,
   input wire logic [PAGE_BITS-1:0] evicted_page
);

   // An eviction only happens on a page fault.
   a_evict_needs_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && evicted_valid |-> fault)
      else $error("eviction reported on a hit");

   // The evicted page field is zero when nothing was evicted.
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !evicted_valid |-> (evicted_page == '0))
      else $error("evicted page nonzero without eviction");

   // No result is shown in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(fault) &&
      $stable(frame_slot) && $stable(evicted_valid) && $stable(evicted_page))
      else $error("stalled result changed");

endmodule

bind clock_page_replacement cpr_checker #(
   .PAGE_BITS (PAGE_BITS)
) u_cpr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .fault         (rsp_ch.fault),
   .frame_slot    (rsp_ch.frame_slot),
   .evicted_valid (rsp_ch.evicted_valid),
   .evicted_page  (rsp_ch.evicted_page)
);

`default_nettype wire

// File: test/cpr_fault_check.sv
// ----------------------------------------------------------------------------
// cpr_fault_check
// Watches the page reference, result and register channels of the clock page
// replacement block. It keeps its own copy of the frame ring, works out the
// result of every accepted reference and compares each returned result with
// the oldest outstanding one.
// ----------------------------------------------------------------------------
module cpr_fault_check
   import cpr_pkg::*;
#(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cpr_req_if                         req_mon,
   cpr_rsp_if                         rsp_mon,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic                  csr_pready,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                         mismatches,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Full result of one page reference.
   typedef struct packed {
      cpr_result_type       ctl;
      logic [PAGE_BITS-1:0] evicted_page;
   } page_outcome_type;

   // Shadow copy of the frame ring and the frame count setting.
   logic [PAGE_BITS-1:0]  frame_page [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] ref_mark;
   int unsigned           filled;
   logic [ACTIVE_W-1:0]   active_frames;
   page_outcome_type      pending_outcomes [$];
   int                    results_checked;

   // Looks up one page, updates the shadow ring and returns the result.
   function automatic page_outcome_type resolve_reference(
      input logic [PAGE_BITS-1:0] page);
      page_outcome_type res;
      int unsigned      limit;
      int unsigned      marked;
      int unsigned      slot;
      bit               hit;
      bit               found;
      res   = '0;
      hit   = 1'b0;
      found = 1'b0;
      slot  = 0;
      // A setting of zero acts as one; anything above the ring size saturates.
      limit = active_frames;
      if (limit < 1) limit = 1;
      if (limit > MAX_FRAMES) limit = MAX_FRAMES;

      // Lowest matching filled slot wins.
      for (int i = 0; i < filled; i++) begin
         if (!hit && frame_page[i] == page) begin
            hit  = 1'b1;
            slot = i;
         end
      end

      if (!hit) begin
         res.ctl.fault = 1'b1;
         if (filled < limit) begin
            // Free slot left: append in order.
            slot             = filled;
            frame_page[slot] = page;
            filled++;
         end else begin
            // Ring full (or setting lowered below the fill): replace the frame
            // after the referenced one, wrapping over the filled frames.
            marked = filled - 1;
            for (int i = 0; i < filled; i++) begin
               if (!found && ref_mark[i]) begin
                  found  = 1'b1;
                  marked = i;
               end
            end
            slot                  = (marked + 1 >= filled) ? 0 : marked + 1;
            res.ctl.evicted_valid = 1'b1;
            res.evicted_page      = frame_page[slot];
            frame_page[slot]      = page;
         end
      end

      ref_mark             = '0;
      ref_mark[slot]       = 1'b1;
      res.ctl.frame_slot   = FRAME_SLOT_W'(slot);
      return res;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] wanted);
      $display("%0t ns: result %0d: %s is 0x%0h, predicted 0x%0h",
               $realtime, results_checked, field, got, wanted);
      mismatches++;
   endtask

   // Follow register writes, predict each request and check each result.
   always @(posedge clock) begin : track
      page_outcome_type want;
      if (reset) begin
         ref_mark        = '0;
         filled          = 0;
         active_frames   = ACTIVE_RESET;
         results_checked = 0;
         mismatches      = 0;
         pending_outcomes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == CSR_IDX_ACTIVE_FRAMES) begin
            active_frames = csr_pwdata[ACTIVE_W-1:0];
         end

         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with no request outstanding", 0, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_mon.fault !== want.ctl.fault)
                  report_mismatch("fault", rsp_mon.fault, want.ctl.fault);
               if (rsp_mon.frame_slot !== want.ctl.frame_slot)
                  report_mismatch("frame_slot", rsp_mon.frame_slot, want.ctl.frame_slot);
               if (rsp_mon.evicted_valid !== want.ctl.evicted_valid)
                  report_mismatch("evicted_valid", rsp_mon.evicted_valid,
                                  want.ctl.evicted_valid);
               if (rsp_mon.evicted_page !== want.evicted_page)
                  report_mismatch("evicted_page", rsp_mon.evicted_page, want.evicted_page);
            end
            results_checked++;
         end

         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            pending_outcomes.push_back(resolve_reference(req_mon.page));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives page references and frame count settings into the clock page
// replacement block, idles and stalls both channels at random, and gives the
// verdict from the mismatch count of the result checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAMES      = 8;
   localparam int PAGE_BITS       = 20;
   localparam int POOL_DEPTH      = 16;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int QUIET_LIMIT     = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [cpr_pkg::CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [cpr_pkg::CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [cpr_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   // Stimulus controls: calm turns off random idling, and each bump of
   // stall_asked makes the result side hold off for a long stretch.
   logic calm = 1'b0;
   int   stall_asked  = 0;
   int   stall_served = 0;
   int   mismatches;
   int   outstanding;
   int   quiet_cycles = 0;
   logic [PAGE_BITS-1:0] page_pool [POOL_DEPTH];

   cpr_req_if #(.PAGE_BITS(PAGE_BITS)) req_if ();
   cpr_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_if ();

   clock_page_replacement #(
      .MAX_FRAMES(MAX_FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   cpr_fault_check #(
      .MAX_FRAMES(MAX_FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) fault_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_pready (csr_pready),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   // 12 ns clock.
   always #6 clock = ~clock;

   // Result side: random stalls, plus a long hold-off whenever one is asked.
   initial begin : rsp_drain
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_asked != stall_served) begin
            stall_served++;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // Ends the run if nothing moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one page request, with an occasional idle gap first.
   // Called and returns at a falling edge; valid stays high on return.
   task automatic send_page(input logic [PAGE_BITS-1:0] pg);
      if (!calm && $urandom_range(99) < 8) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.page  <= pg;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Drops valid and waits until every outstanding result has come back.
   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the frame count register, with random upper data bits.
   task automatic write_active_frames(input logic [cpr_pkg::ACTIVE_W-1:0] setting);
      logic [cpr_pkg::CSR_DATA_W-1:0] wdata;
      logic [cpr_pkg::CSR_ADDR_W-1:0] waddr;
      wdata                          = $urandom();
      wdata[cpr_pkg::ACTIVE_W-1:0]   = setting;
      waddr                          = '0;
      waddr[2]                       = cpr_pkg::CSR_IDX_ACTIVE_FRAMES;
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= waddr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drains the block, changes the setting and draws a fresh working set.
   task automatic start_phase(input logic [cpr_pkg::ACTIVE_W-1:0] setting);
      quiesce();
      write_active_frames(setting);
      foreach (page_pool[i]) page_pool[i] = PAGE_BITS'($urandom());
   endtask

   // Random requests, mostly from a small working set so that hits and
   // evictions both happen, with extreme and fully random pages mixed in.
   task automatic send_random(input int count, input int pool_n);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 6)
            send_page(pick[0] ? '1 : '0);
         else if (pick < 75)
            send_page(page_pool[$urandom_range(pool_n - 1)]);
         else
            send_page(PAGE_BITS'($urandom()));
      end
   endtask

   initial begin : stimulus
      req_if.valid = 1'b0;
      req_if.page  = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A setting of zero behaves as a ring of one: once it is filled, every new page evicts.
      start_phase(4'd0);
      send_page('0);
      send_page('0);
      send_page('1);
      send_page('1);
      send_page('0);
      send_random(40, 3);

      // Ring of one, set explicitly.
      start_phase(4'd1);
      send_page(20'hA5A5A);
      send_random(40, 3);

      // Ring grows to three; the victim follows the referenced frame and wraps.
      start_phase(4'd3);
      send_page(20'h5A5A5);
      send_page(20'h0F0F0);
      send_page(20'h5A5A5);
      send_page(20'hFFFFF);
      send_page(20'h12345);
      send_page(20'h12345);
      send_page(20'hFFFFF);
      send_random(80, 5);

      // Setting lowered below the fill: the ring stays at three frames.
      start_phase(4'd2);
      send_random(60, 5);

      start_phase(4'd5);
      send_random(100, 8);

      // Setting above the ring size saturates at the full ring.
      start_phase(4'd15);
      send_random(300, 12);
      calm <= 1'b1;
      send_random(300, 12);
      calm <= 1'b0;
      stall_asked <= stall_asked + 1;
      send_random(300, 12);

      start_phase(4'd8);
      stall_asked <= stall_asked + 1;
      send_random(250, 10);

      quiesce();
      if (mismatches == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
